[hdl/pcf_pkg.sv]
// shared types, constants and helpers for the pairwise charge force block
package pcf_pkg;

  localparam int PARTICLE_COUNT_DEF = 1024;
  localparam int FRACTION_BITS_DEF  = 16;
  localparam logic [31:0] GAIN_RESET = 32'd6554;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 32;
  localparam int CHG_W   = 16;
  localparam int LANES   = 3;
  localparam int UNIT_BITS = 30;
  localparam int DEN_W   = 33;
  localparam logic [32:0] MAG_CAP = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -33'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

[hdl/pairwise_charge_force.sv]
// pairwise coulomb force with per-particle force accumulators
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | indexes, positions, charges
//  out     | output    | out_valid/out_ready  | pair force, both totals, coincident
//  cfg     | input     | cfg_valid/cfg_ready  | coupling gain (cfg_data)
//
//  one request at a time: the bit-serial divide/sqrt unit works on OPW-bit operands,
//  OPW = max(2*FRACTION_BITS+46, 66), so 78 at sixteen fraction bits
//  coincident particles skip the arithmetic
//  after reset a clearing pass zeroes every entry of the store; no input meanwhile
//  a new request is taken while the previous result still waits at the output
module pairwise_charge_force #(
  parameter int PARTICLE_COUNT = pcf_pkg::PARTICLE_COUNT_DEF,
  parameter int FRACTION_BITS  = pcf_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_first_index,
  input  logic [9:0]  in_second_index,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic signed [15:0] in_first_charge,
  input  logic signed [15:0] in_second_charge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_pair_force_x,
  output logic signed [31:0] out_pair_force_y,
  output logic signed [31:0] out_pair_force_z,
  output logic signed [31:0] out_first_total_x,
  output logic signed [31:0] out_first_total_y,
  output logic signed [31:0] out_first_total_z,
  output logic signed [31:0] out_second_total_x,
  output logic signed [31:0] out_second_total_y,
  output logic signed [31:0] out_second_total_z,
  output logic        out_coincident,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW  = $clog2(PARTICLE_COUNT);
  localparam int SH  = 2 * FRACTION_BITS - 16;
  localparam int XW  = 62 + SH;
  localparam int DNW = (XW > 63) ? XW : 63;
  localparam int OPW = (DNW > 66) ? DNW : 66;
  localparam int IW  = pcf_pkg::IDX_W;
  localparam int RW  = 32 * pcf_pkg::LANES;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_AM   = 4'd4;
  localparam logic [3:0] S_DIV1 = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_UDIV = 4'd7;
  localparam logic [3:0] S_FM   = 4'd8;
  localparam logic [3:0] S_FS   = 4'd9;
  localparam logic [3:0] S_RDA  = 4'd10;
  localparam logic [3:0] S_WA   = 4'd11;
  localparam logic [3:0] S_RDB  = 4'd12;
  localparam logic [3:0] S_WB   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          go_r, go_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   gain_r, gain_nxt;

  logic [IW-1:0] ia_r, ib_r;
  logic [32:0]   dmag_r [3];
  logic          dneg_r [3];
  logic [30:0]   qqmag_r;
  logic          aneg_r;
  logic [65:0]   s_r;
  logic [65:0]   prod_r;
  logic [32:0]   root_r;
  logic [OPW-1:0] q1_r;
  logic [32:0]   mag_r;
  logic [30:0]   u_r;
  logic [31:0]   f_r  [3];
  logic [31:0]   na_r [3];
  logic [31:0]   nb_r [3];
  logic          coin_r;
  logic [31:0]   of_r [3];
  logic [31:0]   oa_r [3];
  logic [31:0]   ob_r [3];
  logic          ocoin_r;

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [32:0] dd [3];
  logic signed [31:0] qq;

  pcf_pkg::iter_cmd_t  icmd;
  pcf_pkg::iter_stat_t istat;
  logic [OPW-1:0]      inum;
  logic [OPW-1:0]      ires;

  logic [32:0]   mul_a, mul_b;
  logic [35:0]   fm;
  logic          fneg;
  logic [31:0]   fval;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic [IW+AW-1:0] ia_ext, ib_ext;
  logic          ia_ok, ib_ok;
  logic [31:0]   upd [3];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  assign pa[0] = in_first_x;  assign pa[1] = in_first_y;  assign pa[2] = in_first_z;
  assign pb[0] = in_second_x; assign pb[1] = in_second_y; assign pb[2] = in_second_z;

  always_comb begin
    for (int i = 0; i < pcf_pkg::LANES; i++) begin
      dd[i] = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
    end
    qq = 32'(in_first_charge) * 32'(in_second_charge);
  end

  assign ia_ext = (IW + AW)'(ia_r);
  assign ib_ext = (IW + AW)'(ib_r);
  assign ia_ok  = (32'(ia_r) < 32'(PARTICLE_COUNT));
  assign ib_ok  = (32'(ib_r) < 32'(PARTICLE_COUNT));

  // shared multiplier operand select
  always_comb begin
    mul_a = dmag_r[k_r];
    mul_b = dmag_r[k_r];
    if (state_r == S_AM) begin
      mul_a = {1'b0, gain_r};
      mul_b = {2'b00, qqmag_r};
    end else if (state_r == S_FM) begin
      mul_a = mag_r;
      mul_b = {2'b00, u_r};
    end
  end

  always_comb begin
    fm   = prod_r[65:pcf_pkg::UNIT_BITS];
    fneg = aneg_r ^ dneg_r[k_r];
    if (fneg) fval = (fm > 36'h0_8000_0000) ? 32'h8000_0000 : (~fm[31:0] + 32'd1);
    else      fval = (fm > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : fm[31:0];
  end

  // iterator operands and start
  always_comb begin
    icmd.start     = 1'b0;
    icmd.sqrt_mode = (state_r == S_SQRT);
    inum           = '0;
    case (state_r)
      S_SQRT: inum = OPW'({s_r, OPW'(0)} >> 66);
      S_DIV1: inum = OPW'(prod_r[61:0]) << SH;
      S_DIV2: inum = q1_r;
      S_UDIV: inum = OPW'({dmag_r[k_r], 30'd0});
      default: inum = '0;
    endcase
    // coincident particles never start the iterator
    if ((state_r == S_SQRT || state_r == S_DIV1 || state_r == S_DIV2 ||
         state_r == S_UDIV) && !go_r && !(state_r == S_SQRT && s_r == 66'd0)) begin
      icmd.start = 1'b1;
    end
  end

  // read-modify-write lane update
  always_comb begin
    for (int i = 0; i < pcf_pkg::LANES; i++) begin
      if (state_r == S_WA) begin
        upd[i] = pcf_pkg::sat33((ia_ok ? {ram_rdata[32*i+31], ram_rdata[32*i +: 32]} : 33'sd0)
                                + {f_r[i][31], f_r[i]});
      end else begin
        upd[i] = pcf_pkg::sat33((ib_ok ? {ram_rdata[32*i+31], ram_rdata[32*i +: 32]} : 33'sd0)
                                - {f_r[i][31], f_r[i]});
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ia_ext[AW-1:0];
    ram_wdata = {upd[2], upd[1], upd[0]};
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
      end
      S_WA:  ram_we = ia_ok;
      S_RDB: ram_addr = ib_ext[AW-1:0];
      S_WB: begin
        ram_addr = ib_ext[AW-1:0];
        ram_we   = ib_ok;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    go_nxt        = go_r;
    out_valid_nxt = out_valid_r;
    gain_nxt      = gain_r;
    if (cfg_valid) gain_nxt = cfg_data;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (icmd.start) go_nxt = 1'b1;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(PARTICLE_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SQ;
          k_nxt     = '0;
        end
      end
      S_SQ: begin
        if (k_r == 2'd2) k_nxt = '0;
        else             k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) state_nxt = S_AM;
      end
      S_AM: begin
        // last square accumulates here
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (s_r == 66'd0) begin
          state_nxt = S_RDA;
          go_nxt    = 1'b0;
        end else if (go_r && istat.done) begin
          go_nxt    = 1'b0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: if (go_r && istat.done) begin
        go_nxt    = 1'b0;
        state_nxt = S_DIV2;
      end
      S_DIV2: if (go_r && istat.done) begin
        go_nxt    = 1'b0;
        state_nxt = S_UDIV;
        k_nxt     = '0;
      end
      S_UDIV: if (go_r && istat.done) begin
        go_nxt    = 1'b0;
        state_nxt = S_FM;
      end
      S_FM: state_nxt = S_FS;
      S_FS: begin
        if (k_r == 2'd2) begin
          state_nxt = S_RDA;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_UDIV;
        end
      end
      S_RDA: state_nxt = S_WA;
      S_WA:  state_nxt = S_RDB;
      S_RDB: state_nxt = S_WB;
      S_WB:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      k_r         <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= pcf_pkg::GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      k_r         <= k_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_SQ || state_r == S_AM || state_r == S_FM) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_SQ && k_r != 2'd0) s_r <= s_r + prod_r;
    if (state_r == S_AM) s_r <= s_r + prod_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ia_r    <= in_first_index;
          ib_r    <= in_second_index;
          s_r     <= '0;
          aneg_r  <= qq[31];
          qqmag_r <= qq[31] ? 31'(-qq) : qq[30:0];
          for (int i = 0; i < pcf_pkg::LANES; i++) begin
            dneg_r[i] <= dd[i][32];
            dmag_r[i] <= dd[i][32] ? 33'(-dd[i]) : dd[i];
            f_r[i]    <= '0;
          end
        end
      end
      S_SQRT: begin
        coin_r <= (s_r == 66'd0);
        if (go_r && istat.done) root_r <= ires[32:0];
      end
      S_DIV1: if (go_r && istat.done) q1_r <= ires;
      S_DIV2: if (go_r && istat.done) begin
        mag_r <= (ires > OPW'(pcf_pkg::MAG_CAP)) ? pcf_pkg::MAG_CAP : ires[32:0];
      end
      S_UDIV: if (go_r && istat.done) u_r <= ires[30:0];
      S_FS:   f_r[k_r] <= fval;
      S_WA: begin
        for (int i = 0; i < pcf_pkg::LANES; i++) na_r[i] <= upd[i];
      end
      S_WB: begin
        for (int i = 0; i < pcf_pkg::LANES; i++) nb_r[i] <= upd[i];
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          for (int i = 0; i < pcf_pkg::LANES; i++) begin
            of_r[i] <= f_r[i];
            oa_r[i] <= na_r[i];
            ob_r[i] <= nb_r[i];
          end
          ocoin_r <= coin_r;
        end
      end
      default: ;
    endcase
  end

  assign out_pair_force_x   = of_r[0];
  assign out_pair_force_y   = of_r[1];
  assign out_pair_force_z   = of_r[2];
  assign out_first_total_x  = oa_r[0];
  assign out_first_total_y  = oa_r[1];
  assign out_first_total_z  = oa_r[2];
  assign out_second_total_x = ob_r[0];
  assign out_second_total_y = ob_r[1];
  assign out_second_total_z = ob_r[2];
  assign out_coincident     = ocoin_r;

  pcf_iter #(.OPW(OPW)) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (icmd),
    .num_in (inum),
    .den_in (root_r),
    .stat   (istat),
    .result (ires)
  );

  pcf_ram #(.WIDTH(RW), .DEPTH(PARTICLE_COUNT)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (ram_wdata),
    .rdata_r (ram_rdata)
  );

  // sqrt result only becomes the divisor once the sqrt has finished
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready) else $error("request taken during clear pass");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    icmd.start |-> !istat.busy) else $error("iterator started while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("result raised out of turn");

  a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ocoin_r) |-> (of_r[0] == 32'd0 && of_r[1] == 32'd0 && of_r[2] == 32'd0))
    else $error("coincident result carries force");

endmodule

[hdl/pcf_ram.sv]
// generic single port ram with registered read
module pcf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

[hdl/pcf_iter.sv]
// shared restoring divide / square root unit, one bit or one bit pair a cycle
module pcf_iter #(
  parameter int OPW = 78
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcf_pkg::iter_cmd_t          cmd,
  input  logic [OPW-1:0]              num_in,
  input  logic [pcf_pkg::DEN_W-1:0]   den_in,
  output pcf_pkg::iter_stat_t         stat,
  output logic [OPW-1:0]              result
);

  localparam int CW = $clog2(OPW + 1);
  localparam int SQRT_STEPS = 33;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            mode_r, mode_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [OPW-1:0]  num_r, num_nxt;
  logic [OPW-1:0]  quo_r, quo_nxt;
  logic [35:0]     rem_r, rem_nxt;
  logic [pcf_pkg::DEN_W-1:0] den_r, den_nxt;

  logic [35:0] opa, opb;
  logic [36:0] diff;
  logic        ge;
  logic        last;

  // one compare-subtract serves both operations
  always_comb begin
    if (mode_r) begin
      opa = {rem_r[33:0], num_r[OPW-1:OPW-2]};
      opb = {1'b0, quo_r[32:0], 2'b01};
    end else begin
      opa = {2'b00, rem_r[32:0], num_r[OPW-1]};
      opb = {3'b000, den_r};
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[36];
    last = mode_r ? (cnt_r == CW'(SQRT_STEPS - 1)) : (cnt_r == CW'(OPW - 1));
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (cmd.start && !busy_r) begin
      busy_nxt = 1'b1;
      mode_nxt = cmd.sqrt_mode;
      cnt_nxt  = '0;
      num_nxt  = num_in;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den_in;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[35:0] : opa;
      quo_nxt = {quo_r[OPW-2:0], ge};
      num_nxt = mode_r ? {num_r[OPW-3:0], 2'b00} : {num_r[OPW-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = quo_r;

endmodule

[test/tb_top.sv]
// self-checking testbench for the pairwise charge force block
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC = pcf_pkg::FRACTION_BITS_DEF;
  localparam int NPART = pcf_pkg::PARTICLE_COUNT_DEF;

  typedef struct packed {
    logic [9:0] ia;
    logic [9:0] ib;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic signed [15:0] qa, qb;
  } pair_req_t;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz;
    logic signed [31:0] ta_x, ta_y, ta_z;
    logic signed [31:0] tb_x, tb_y, tb_z;
    logic coinc;
  } force_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] in_first_index = '0, in_second_index = '0;
  logic signed [31:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [31:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic signed [15:0] in_first_charge = '0, in_second_charge = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pair_force_x, out_pair_force_y, out_pair_force_z;
  logic signed [31:0] out_first_total_x, out_first_total_y, out_first_total_z;
  logic signed [31:0] out_second_total_x, out_second_total_y, out_second_total_z;
  logic out_coincident;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  pairwise_charge_force u_top (.*);

  // predictor copy of register and accumulator store
  logic [31:0] gain_q = pcf_pkg::GAIN_RESET;
  logic signed [31:0] acc_x [NPART];
  logic signed [31:0] acc_y [NPART];
  logic signed [31:0] acc_z [NPART];

  force_res_t expected_forces[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic force_res_t coulomb_update(input pair_req_t q);
    force_res_t res;
    logic signed [32:0] d [3];
    logic [32:0] dm [3];
    logic [67:0] sumsq, trial;
    logic [33:0] root;
    logic signed [31:0] qq;
    logic [127:0] num, mag, unit, fm;
    logic signed [63:0] f [3];
    logic neg_a, neg;
    logic signed [31:0] na [3];
    logic signed [31:0] nb [3];
    logic signed [31:0] old;
    d[0] = 33'(q.ax) - 33'(q.bx);
    d[1] = 33'(q.ay) - 33'(q.by);
    d[2] = 33'(q.az) - 33'(q.bz);
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      dm[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sumsq += 68'(dm[i]) * 68'(dm[i]);
      f[i] = 0;
    end
    res.coinc = (sumsq == 0);
    if (!res.coinc) begin
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        trial = 68'(root | (34'd1 << b));
        if (trial * trial <= sumsq) root = trial[33:0];
      end
      qq = 32'(q.qa) * 32'(q.qb);
      neg_a = qq < 0;
      num = (128'(gain_q) * 128'(qq < 0 ? -64'(qq) : 64'(qq))) << (2 * FRAC - 16);
      mag = num / (128'(root) * 128'(root));
      if (mag > 128'(pcf_pkg::MAG_CAP)) mag = 128'(pcf_pkg::MAG_CAP);
      for (int i = 0; i < 3; i++) begin
        unit = (128'(dm[i]) << pcf_pkg::UNIT_BITS) / 128'(root);
        fm = (mag * unit) >> pcf_pkg::UNIT_BITS;
        neg = neg_a != d[i][32];
        if (neg) f[i] = (fm > 128'd2147483648) ? -64'sd2147483648 : -$signed(64'(fm));
        else f[i] = (fm > 128'd2147483647) ? 64'sd2147483647 : $signed(64'(fm));
      end
    end
    // first entry is written before the second is read, so equal indexes chain
    old = acc_x[q.ia]; na[0] = clip32(64'(old) + f[0]); acc_x[q.ia] = na[0];
    old = acc_x[q.ib]; nb[0] = clip32(64'(old) - f[0]); acc_x[q.ib] = nb[0];
    old = acc_y[q.ia]; na[1] = clip32(64'(old) + f[1]); acc_y[q.ia] = na[1];
    old = acc_y[q.ib]; nb[1] = clip32(64'(old) - f[1]); acc_y[q.ib] = nb[1];
    old = acc_z[q.ia]; na[2] = clip32(64'(old) + f[2]); acc_z[q.ia] = na[2];
    old = acc_z[q.ib]; nb[2] = clip32(64'(old) - f[2]); acc_z[q.ib] = nb[2];
    res.fx = f[0][31:0]; res.fy = f[1][31:0]; res.fz = f[2][31:0];
    res.ta_x = na[0]; res.ta_y = na[1]; res.ta_z = na[2];
    res.tb_x = nb[0]; res.tb_y = nb[1]; res.tb_z = nb[2];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // result checker, ready stalls drawn each cycle
  always @(posedge clk) begin
    force_res_t want;
    if (out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        want = expected_forces.pop_front();
        if (out_pair_force_x !== want.fx) report_mismatch("pair_force_x", out_pair_force_x, want.fx);
        if (out_pair_force_y !== want.fy) report_mismatch("pair_force_y", out_pair_force_y, want.fy);
        if (out_pair_force_z !== want.fz) report_mismatch("pair_force_z", out_pair_force_z, want.fz);
        if (out_first_total_x !== want.ta_x) report_mismatch("first_total_x", out_first_total_x, want.ta_x);
        if (out_first_total_y !== want.ta_y) report_mismatch("first_total_y", out_first_total_y, want.ta_y);
        if (out_first_total_z !== want.ta_z) report_mismatch("first_total_z", out_first_total_z, want.ta_z);
        if (out_second_total_x !== want.tb_x) report_mismatch("second_total_x", out_second_total_x, want.tb_x);
        if (out_second_total_y !== want.tb_y) report_mismatch("second_total_y", out_second_total_y, want.tb_y);
        if (out_second_total_z !== want.tb_z) report_mismatch("second_total_z", out_second_total_z, want.tb_z);
        if (out_coincident !== want.coinc) report_mismatch("coincident", 32'(out_coincident), 32'(want.coinc));
      end
    end
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pair(input pair_req_t q);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_index <= q.ia;  in_second_index <= q.ib;
    in_first_x <= q.ax; in_first_y <= q.ay; in_first_z <= q.az;
    in_second_x <= q.bx; in_second_y <= q.by; in_second_z <= q.bz;
    in_first_charge <= q.qa; in_second_charge <= q.qb;
    do @(posedge clk); while (!in_ready);
    expected_forces.push_back(coulomb_update(q));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gain(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    gain_q = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic pair_req_t make_pair(input logic [9:0] ia, input logic [9:0] ib,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] az, input logic signed [31:0] bx,
      input logic signed [31:0] by, input logic signed [31:0] bz,
      input logic signed [15:0] qa, input logic signed [15:0] qb);
    pair_req_t q;
    q.ia = ia; q.ib = ib; q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz; q.qa = qa; q.qb = qb;
    return q;
  endfunction

  function automatic pair_req_t random_pair();
    pair_req_t q;
    int unsigned mode;
    int unsigned span;
    q.ia = ($urandom_range(99) < 70) ? 10'($urandom_range(7)) : 10'($urandom);
    q.ib = ($urandom_range(99) < 70) ? 10'($urandom_range(7)) : 10'($urandom);
    q.qa = 16'($urandom);
    q.qb = 16'($urandom);
    mode = $urandom_range(99);
    q.ax = $urandom; q.ay = $urandom; q.az = $urandom;
    if (mode < 4) begin
      q.bx = q.ax; q.by = q.ay; q.bz = q.az;
    end else if (mode < 70) begin
      // nearby particles: each axis offset by up to a random span of 2**4 to 2**24
      span = 32'd1 << $urandom_range(4, 24);
      q.bx = q.ax + $signed($urandom_range(2 * span) - span);
      q.by = q.ay + $signed($urandom_range(2 * span) - span);
      q.bz = q.az + $signed($urandom_range(2 * span) - span);
    end else begin
      q.bx = $urandom; q.by = $urandom; q.bz = $urandom;
    end
    return q;
  endfunction

  task automatic test_directed;
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_pair(make_pair(0, 1, 0, 0, 0, 0, 0, 0, 16'sh0100, 16'sh0100));
    send_pair(make_pair(5, 5, 7, -3, 9, 7, -3, 9, mx[15:0], mn[15:0]));
    send_pair(make_pair(0, 1023, mx, mx, mx, mn, mn, mn, 16'sh7FFF, 16'sh7FFF));
    send_pair(make_pair(1023, 0, mn, mn, mn, mx, mx, mx, 16'sh8000, 16'sh8000));
    send_pair(make_pair(2, 3, 32'sh10000, 0, 0, 0, 0, 0, 16'sh0100, -16'sh0100));
    send_pair(make_pair(3, 3, 0, 32'sh20000, 0, 0, 0, 0, 16'sh0200, 16'sh0300));
    send_pair(make_pair(4, 6, 0, 0, -32'sh8000, 0, 0, 0, 16'sh8000, 16'sh7FFF));
    send_pair(make_pair(7, 8, 1, 0, 0, 0, 0, 0, 16'sh7FFF, 16'sh7FFF));
    send_pair(make_pair(8, 7, 0, 0, 0, 0, 1, -1, 16'sh0001, 16'shFFFF));
  endtask

  task automatic test_saturation;
    // huge magnitude at minimum spacing, hammered until the totals clip
    for (int i = 0; i < 12; i++)
      send_pair(make_pair(9, 10, 1, -1, 1, 0, 0, 0, 16'sh7FFF, 16'sh7FFF));
    send_pair(make_pair(10, 10, 0, 0, 1, 0, 0, 0, 16'sh8000, 16'sh7FFF));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  initial begin
    for (int i = 0; i < NPART; i++) begin
      acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26; recv_idle_pct = 47;
    test_directed();
    write_gain(32'hFFFF_FFFF);
    test_saturation();
    test_directed();
    write_gain(32'd0);
    test_directed();
    test_random(100);
    write_gain(32'h0001_0000);
    test_random(500);
    send_idle_pct = 47; recv_idle_pct = 26;
    write_gain($urandom);
    test_random(400);
    write_gain(pcf_pkg::GAIN_RESET);
    test_random(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_gain($urandom_range(1, 32'h0010_0000));
    test_random(300);
    drain();
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_forces.size() == 0)
      $display("pairwise_charge_force verification clean");
    else
      $display("pairwise_charge_force verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("pairwise_charge_force verification failed");
    $finish;
  end

endmodule
